// ===== src/fpm_pkg.sv =====
package fpm_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    // matrix entries, one divider lane each
    localparam int NUM_LANES = 6;
    localparam int LANE_X_SCALE = 0;
    localparam int LANE_X_OFFSET = 1;
    localparam int LANE_Y_SCALE = 2;
    localparam int LANE_Y_OFFSET = 3;
    localparam int LANE_D_SCALE = 4;
    localparam int LANE_D_OFFSET = 5;

endpackage

// ===== src/fpm_prep.sv =====
module fpm_prep
    import fpm_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int DW = WORD_BITS + 1,
    localparam int QB = WORD_BITS + 1,
    localparam int NW = (WORD_BITS + 1 + FRAC_BITS > 2 * WORD_BITS + 2) ?
                        (WORD_BITS + 1 + FRAC_BITS) : (2 * WORD_BITS + 2)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [WORD_BITS-1:0] l_in,
    input  logic [WORD_BITS-1:0] r_in,
    input  logic [WORD_BITS-1:0] b_in,
    input  logic [WORD_BITS-1:0] t_in,
    input  logic [WORD_BITS-1:0] n_in,
    input  logic [WORD_BITS-1:0] f_in,
    output logic                 out_valid,
    output logic                 out_invalid,
    output logic [DW-1:0]        den_out [NUM_LANES],
    output logic [DW-1:0]        rem_out [NUM_LANES],
    output logic [QB-1:0]        nq_out  [NUM_LANES],
    output logic                 neg_out [NUM_LANES],
    output logic                 ovf_out [NUM_LANES]
);

    // stage a: sums, differences, argument check
    logic                 va_reg, vb_reg, vc_reg;
    logic                 inva_reg, invb_reg, invc_reg;
    logic [WORD_BITS:0]   rml_reg, rpl_reg, tmb_reg, tpb_reg, fmn_reg, fpn_reg, two_n_reg;
    logic [WORD_BITS-1:0] fa_reg;

    logic [WORD_BITS:0] le, re, be, te, ne, fe;
    logic               inv_next;

    always_comb begin
        le = {l_in[WORD_BITS-1], l_in};
        re = {r_in[WORD_BITS-1], r_in};
        be = {b_in[WORD_BITS-1], b_in};
        te = {t_in[WORD_BITS-1], t_in};
        ne = {n_in[WORD_BITS-1], n_in};
        fe = {f_in[WORD_BITS-1], f_in};
        inv_next = (r_in == l_in) || (t_in == b_in) || (n_in == f_in) ||
                   n_in[WORD_BITS-1] || f_in[WORD_BITS-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rml_reg   <= re - le;
            rpl_reg   <= re + le;
            tmb_reg   <= te - be;
            tpb_reg   <= te + be;
            fmn_reg   <= fe - ne;
            fpn_reg   <= fe + ne;
            two_n_reg <= {n_in, 1'b0};
            fa_reg    <= f_in;
            inva_reg  <= inv_next;
        end
    end

    // stage b: magnitudes, aligned numerators, 2fn product
    logic [NW-1:0] num_reg [NUM_LANES];
    logic [DW-1:0] den_reg [NUM_LANES];
    logic          nb_reg  [NUM_LANES];

    function automatic logic [WORD_BITS:0] mag(input logic [WORD_BITS:0] s);
        return s[WORD_BITS] ? (~s + 1'b1) : s;
    endfunction

    function automatic logic [NW-1:0] align(input logic [WORD_BITS:0] s);
        return NW'(mag(s)) << FRAC_BITS;
    endfunction

    logic [2*WORD_BITS-1:0] prod;

    always_comb begin
        prod = fa_reg * two_n_reg[WORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[LANE_X_SCALE]  <= align(two_n_reg);
            num_reg[LANE_X_OFFSET] <= align(rpl_reg);
            num_reg[LANE_Y_SCALE]  <= align(two_n_reg);
            num_reg[LANE_Y_OFFSET] <= align(tpb_reg);
            num_reg[LANE_D_SCALE]  <= align(fpn_reg);
            num_reg[LANE_D_OFFSET] <= NW'(prod);
            den_reg[LANE_X_SCALE]  <= mag(rml_reg);
            den_reg[LANE_X_OFFSET] <= mag(rml_reg);
            den_reg[LANE_Y_SCALE]  <= mag(tmb_reg);
            den_reg[LANE_Y_OFFSET] <= mag(tmb_reg);
            den_reg[LANE_D_SCALE]  <= mag(fmn_reg);
            den_reg[LANE_D_OFFSET] <= mag(fmn_reg);
            nb_reg[LANE_X_SCALE]   <= two_n_reg[WORD_BITS] ^ rml_reg[WORD_BITS];
            nb_reg[LANE_X_OFFSET]  <= rpl_reg[WORD_BITS] ^ rml_reg[WORD_BITS];
            nb_reg[LANE_Y_SCALE]   <= two_n_reg[WORD_BITS] ^ tmb_reg[WORD_BITS];
            nb_reg[LANE_Y_OFFSET]  <= tpb_reg[WORD_BITS] ^ tmb_reg[WORD_BITS];
            // depth numerators carry a minus sign
            nb_reg[LANE_D_SCALE]   <= ~fpn_reg[WORD_BITS] ^ fmn_reg[WORD_BITS];
            nb_reg[LANE_D_OFFSET]  <= ~fmn_reg[WORD_BITS];
            invb_reg <= inva_reg;
        end
    end

    // stage c: overflow check and initial remainder
    logic [DW-1:0] denc_reg [NUM_LANES];
    logic [DW-1:0] remc_reg [NUM_LANES];
    logic [QB-1:0] nqc_reg  [NUM_LANES];
    logic          negc_reg [NUM_LANES];
    logic          ovfc_reg [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                denc_reg[i] <= den_reg[i];
                remc_reg[i] <= num_reg[i][QB+DW-1:QB];
                nqc_reg[i]  <= num_reg[i][QB-1:0];
                negc_reg[i] <= nb_reg[i];
                // quotient at or above 2^(WORD_BITS+1) always saturates
                ovfc_reg[i] <= num_reg[i][NW-1:QB] >= (NW-QB)'(den_reg[i]);
            end
            invc_reg <= invb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    assign out_valid   = vc_reg;
    assign out_invalid = invc_reg;
    assign den_out     = denc_reg;
    assign rem_out     = remc_reg;
    assign nq_out      = nqc_reg;
    assign neg_out     = negc_reg;
    assign ovf_out     = ovfc_reg;

endmodule

// ===== src/fpm_div_step.sv =====
module fpm_div_step
    import fpm_pkg::*;
#(
    parameter int DW = DEF_WORD_BITS + 1,
    parameter int QB = DEF_WORD_BITS + 1
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] den_in,
    input  logic [DW-1:0] rem_in,
    input  logic [QB-1:0] nq_in,
    input  logic          neg_in,
    input  logic          ovf_in,
    output logic [DW-1:0] den_out,
    output logic [DW-1:0] rem_out,
    output logic [QB-1:0] nq_out,
    output logic          neg_out,
    output logic          ovf_out
);

    logic [DW:0]   trial, diff;
    logic          ge;
    logic [DW-1:0] den_reg, rem_reg;
    logic [QB-1:0] nq_reg;
    logic          neg_reg, ovf_reg;

    // numerator bits shift out on top, quotient bits shift in below
    always_comb begin
        trial = {rem_in, nq_in[QB-1]};
        diff  = trial - {1'b0, den_in};
        ge    = trial >= {1'b0, den_in};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= den_in;
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            nq_reg  <= {nq_in[QB-2:0], ge};
            neg_reg <= neg_in;
            ovf_reg <= ovf_in;
        end
    end

    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;
    assign neg_out = neg_reg;
    assign ovf_out = ovf_reg;

endmodule

// ===== src/fpm_div_lane.sv =====
module fpm_div_lane
    import fpm_pkg::*;
#(
    parameter int DW = DEF_WORD_BITS + 1,
    parameter int QB = DEF_WORD_BITS + 1
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] den_in,
    input  logic [DW-1:0] rem_in,
    input  logic [QB-1:0] nq_in,
    input  logic          neg_in,
    input  logic          ovf_in,
    output logic [QB-1:0] q_out,
    output logic          neg_out,
    output logic          ovf_out
);

    logic [DW-1:0] den_s [QB+1];
    logic [DW-1:0] rem_s [QB+1];
    logic [QB-1:0] nq_s  [QB+1];
    logic          neg_s [QB+1];
    logic          ovf_s [QB+1];

    assign den_s[0] = den_in;
    assign rem_s[0] = rem_in;
    assign nq_s[0]  = nq_in;
    assign neg_s[0] = neg_in;
    assign ovf_s[0] = ovf_in;

    for (genvar k = 0; k < QB; k++) begin : g_step
        fpm_div_step #(.DW(DW), .QB(QB)) u_step (
            .aclk    (aclk),
            .en      (en),
            .den_in  (den_s[k]),
            .rem_in  (rem_s[k]),
            .nq_in   (nq_s[k]),
            .neg_in  (neg_s[k]),
            .ovf_in  (ovf_s[k]),
            .den_out (den_s[k+1]),
            .rem_out (rem_s[k+1]),
            .nq_out  (nq_s[k+1]),
            .neg_out (neg_s[k+1]),
            .ovf_out (ovf_s[k+1])
        );
    end

    assign q_out   = nq_s[QB];
    assign neg_out = neg_s[QB];
    assign ovf_out = ovf_s[QB];

endmodule

// ===== src/frustum_projection_matrix_unit.sv =====
// Frustum projection unit: each item carries the six frustum bounds as signed
// fixed-point words and yields the six variable perspective matrix entries,
// quotients truncated toward zero and saturated to the word range. Degenerate
// bounds or a negative near or far plane raise args_invalid and return identity
// entries. The unit is fully pipelined: it takes one item per cycle while the
// output is not stalled, through three setup stages and then six restoring
// dividers of one quotient bit per stage. A stalled output freezes the whole
// pipeline.
module frustum_projection_matrix_unit
    import fpm_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_left_bound,
    input  logic [WORD_BITS-1:0] s_right_bound,
    input  logic [WORD_BITS-1:0] s_bottom_bound,
    input  logic [WORD_BITS-1:0] s_top_bound,
    input  logic [WORD_BITS-1:0] s_near_plane,
    input  logic [WORD_BITS-1:0] s_far_plane,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_BITS-1:0] m_x_scale,
    output logic [WORD_BITS-1:0] m_x_offset,
    output logic [WORD_BITS-1:0] m_y_scale,
    output logic [WORD_BITS-1:0] m_y_offset,
    output logic [WORD_BITS-1:0] m_depth_scale,
    output logic [WORD_BITS-1:0] m_depth_offset,
    output logic                 m_args_invalid
);

    localparam int DW = WORD_BITS + 1;
    localparam int QB = WORD_BITS + 1;

    logic en;
    logic out_valid_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    logic          pv, pinv;
    logic [DW-1:0] pden [NUM_LANES];
    logic [DW-1:0] prem [NUM_LANES];
    logic [QB-1:0] pnq  [NUM_LANES];
    logic          pneg [NUM_LANES];
    logic          povf [NUM_LANES];

    fpm_prep #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .l_in        (s_left_bound),
        .r_in        (s_right_bound),
        .b_in        (s_bottom_bound),
        .t_in        (s_top_bound),
        .n_in        (s_near_plane),
        .f_in        (s_far_plane),
        .out_valid   (pv),
        .out_invalid (pinv),
        .den_out     (pden),
        .rem_out     (prem),
        .nq_out      (pnq),
        .neg_out     (pneg),
        .ovf_out     (povf)
    );

    logic [QB-1:0] q    [NUM_LANES];
    logic          qneg [NUM_LANES];
    logic          qovf [NUM_LANES];

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        fpm_div_lane #(.DW(DW), .QB(QB)) u_lane (
            .aclk    (aclk),
            .en      (en),
            .den_in  (pden[i]),
            .rem_in  (prem[i]),
            .nq_in   (pnq[i]),
            .neg_in  (pneg[i]),
            .ovf_in  (povf[i]),
            .q_out   (q[i]),
            .neg_out (qneg[i]),
            .ovf_out (qovf[i])
        );
    end

    // valid and argument flag ride alongside the divider stages
    logic vld_reg [QB];
    logic inv_reg [QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QB; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= pv;
            for (int k = 1; k < QB; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inv_reg[0] <= pinv;
            for (int k = 1; k < QB; k++) inv_reg[k] <= inv_reg[k-1];
        end
    end

    // sign, saturation, identity substitution
    localparam logic [QB-1:0] POS_LIM = QB'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic [QB-1:0] NEG_LIM = QB'({1'b1, {(WORD_BITS-1){1'b0}}});
    localparam logic [WORD_BITS-1:0] ONE_FX = WORD_BITS'(1) << FRAC_BITS;

    logic [WORD_BITS-1:0] res_next [NUM_LANES];
    logic [WORD_BITS-1:0] res_reg  [NUM_LANES];
    logic                 inv_out_reg;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (!qneg[i]) begin
                res_next[i] = (qovf[i] || q[i] > POS_LIM) ? POS_LIM[WORD_BITS-1:0]
                                                         : q[i][WORD_BITS-1:0];
            end else begin
                res_next[i] = (qovf[i] || q[i] > NEG_LIM) ? NEG_LIM[WORD_BITS-1:0]
                                                         : (~q[i][WORD_BITS-1:0] + 1'b1);
            end
        end
        if (inv_reg[QB-1]) begin
            res_next[LANE_X_SCALE]  = ONE_FX;
            res_next[LANE_X_OFFSET] = '0;
            res_next[LANE_Y_SCALE]  = ONE_FX;
            res_next[LANE_Y_OFFSET] = '0;
            res_next[LANE_D_SCALE]  = ONE_FX;
            res_next[LANE_D_OFFSET] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg     <= res_next;
            inv_out_reg <= inv_reg[QB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_reg[QB-1];
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_x_scale      = res_reg[LANE_X_SCALE];
    assign m_x_offset     = res_reg[LANE_X_OFFSET];
    assign m_y_scale      = res_reg[LANE_Y_SCALE];
    assign m_y_offset     = res_reg[LANE_Y_OFFSET];
    assign m_depth_scale  = res_reg[LANE_D_SCALE];
    assign m_depth_offset = res_reg[LANE_D_OFFSET];
    assign m_args_invalid = inv_out_reg;

endmodule

// ===== src/fpm_checker.sv =====
module fpm_checker
    import fpm_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [WORD_BITS-1:0] m_x_scale,
    input logic [WORD_BITS-1:0] m_x_offset,
    input logic [WORD_BITS-1:0] m_y_offset,
    input logic [WORD_BITS-1:0] m_depth_scale,
    input logic [WORD_BITS-1:0] m_depth_offset,
    input logic                 m_args_invalid
);

    localparam logic [WORD_BITS-1:0] ONE_FX = WORD_BITS'(1) << FRAC_BITS;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_args_invalid |->
            m_x_scale == ONE_FX && m_depth_scale == ONE_FX &&
            m_x_offset == '0 && m_y_offset == '0 && m_depth_offset == '0)
        else $error("rejected bounds without identity entries");

endmodule

bind frustum_projection_matrix_unit fpm_checker #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
) u_fpm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_x_scale      (m_x_scale),
    .m_x_offset     (m_x_offset),
    .m_y_offset     (m_y_offset),
    .m_depth_scale  (m_depth_scale),
    .m_depth_offset (m_depth_offset),
    .m_args_invalid (m_args_invalid)
);
